// ----- design/gpio_port_controller_change_events_top_assert.svh -----
// Assertion macros used by the GPIO change-event top level.
`ifndef GPIO_PORT_CONTROLLER_CHANGE_EVENTS_TOP_ASSERT_SVH
`define GPIO_PORT_CONTROLLER_CHANGE_EVENTS_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define GPCE_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("gpce assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define GPCE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("gpce assertion failed");

`endif

// ----- design/gpce_pkg.sv -----
// Types, codes and port-letter decode for the GPIO change-event block.
`timescale 1ns / 1ps

package gpce_pkg;

	localparam logic [7:0] LETTER_A = 8'h41;
	localparam logic [7:0] LETTER_E = 8'h45;
	localparam logic [7:0] LETTER_H = 8'h48;
	localparam logic [7:0] LETTER_J = 8'h4A;
	localparam logic [7:0] LETTER_Q = 8'h51;

	typedef enum logic [2:0] {
		ACT_WR_OUT   = 3'd0,
		ACT_WR_DIR   = 3'd1,
		ACT_RD_PIN   = 3'd2,
		ACT_SAMPLE   = 3'd3,
		ACT_BASELINE = 3'd4
	} action_t;

	typedef enum logic [1:0] {
		ST_OK           = 2'd0,
		ST_UNKNOWN_PORT = 2'd1,
		ST_BIT_RANGE    = 2'd2,
		ST_RESERVED     = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_EXEC,
		S_SCAN
	} seq_state_t;

	typedef struct packed {
		logic       hit;
		logic [3:0] idx;
	} port_lookup_t;

	typedef struct packed {
		logic       out_we;
		logic       dir_we;
		logic       pin_we;
		logic [2:0] bit_sel;
		logic       level;
		logic [7:0] pins;
	} bank_wr_t;

	typedef struct packed {
		logic [7:0] out_nx;
		logic [7:0] dir_nx;
		logic [7:0] pins;
	} bank_rd_t;

	typedef struct packed {
		status_t    status;
		logic       read_level;
		logic       event_valid;
		logic [7:0] event_port;
		logic [2:0] event_bit;
		logic       event_level;
		logic       last_result;
		logic [7:0] out_latch;
		logic [7:0] dir_latch;
	} rsp_t;

	// Map A..H to 0..7 and J..Q to 8..15; letter I has no port.
	function automatic port_lookup_t port_lookup(input logic [7:0] letter);
		port_lookup_t r;
		r.hit = 1'b0;
		r.idx = 4'd0;
		if (letter >= LETTER_A && letter <= LETTER_H) begin
			r.hit = 1'b1;
			r.idx = 4'(letter - LETTER_A);
		end else if (letter >= LETTER_J && letter <= LETTER_Q) begin
			r.hit = 1'b1;
			r.idx = 4'(letter - LETTER_A - 8'd1);
		end
		return r;
	endfunction

endpackage

// ----- design/gpce_if.sv -----
// Valid/ready channel interfaces for GPIO requests and results.
`timescale 1ns / 1ps

interface gpce_req_if;
	logic       valid;
	logic       ready;
	logic [2:0] action;
	logic [7:0] port_letter;
	logic [7:0] bit_index;
	logic       level;
	logic [7:0] pin_sample;

	modport source (output valid, action, port_letter, bit_index, level, pin_sample,
		input ready);
	modport sink (input valid, action, port_letter, bit_index, level, pin_sample,
		output ready);
endinterface

interface gpce_rsp_if;
	logic               valid;
	logic               ready;
	gpce_pkg::status_t  status;
	logic               read_level;
	logic               event_valid;
	logic [7:0]         event_port;
	logic [2:0]         event_bit;
	logic               event_level;
	logic               last_result;
	logic [7:0]         out_latch;
	logic [7:0]         dir_latch;

	modport source (output valid, status, read_level, event_valid, event_port, event_bit,
		event_level, last_result, out_latch, dir_latch, input ready);
	modport sink (input valid, status, read_level, event_valid, event_port, event_bit,
		event_level, last_result, out_latch, dir_latch, output ready);
endinterface

// ----- design/gpce_bank.sv -----
// Per-port output, direction and sampled-pin registers with bit update.
`timescale 1ns / 1ps

module gpce_bank #(
	parameter int NUM_PORTS = 11
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [3:0]         idx,
	input  gpce_pkg::bank_wr_t wr,
	output gpce_pkg::bank_rd_t rd
);

	localparam int PIDX_W = (NUM_PORTS > 1) ? $clog2(NUM_PORTS) : 1;

	logic [7:0] out_q  [NUM_PORTS];
	logic [7:0] dir_q  [NUM_PORTS];
	logic [7:0] pins_q [NUM_PORTS];

	logic              in_range;
	logic [PIDX_W-1:0] ridx;
	logic [7:0]        mask;
	logic [7:0]        out_cur;
	logic [7:0]        dir_cur;

	assign in_range = ({1'b0, idx} < 5'(NUM_PORTS));
	assign ridx     = idx[PIDX_W-1:0];
	assign mask     = 8'd1 << wr.bit_sel;

	always_comb begin
		out_cur = in_range ? out_q[ridx]  : 8'd0;
		dir_cur = in_range ? dir_q[ridx]  : 8'd0;
		rd.pins = in_range ? pins_q[ridx] : 8'd0;
		rd.out_nx = out_cur;
		rd.dir_nx = dir_cur;
		// show the latch as it stands after a pending single-bit write
		if (wr.out_we) begin
			rd.out_nx = wr.level ? (out_cur | mask) : (out_cur & ~mask);
		end
		if (wr.dir_we) begin
			rd.dir_nx = wr.level ? (dir_cur | mask) : (dir_cur & ~mask);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_PORTS; i++) begin
				out_q[i]  <= 8'd0;
				dir_q[i]  <= 8'd0;
				pins_q[i] <= 8'd0;
			end
		end else if (in_range) begin
			if (wr.out_we) begin
				out_q[ridx] <= rd.out_nx;
			end
			if (wr.dir_we) begin
				dir_q[ridx] <= rd.dir_nx;
			end
			if (wr.pin_we) begin
				pins_q[ridx] <= wr.pins;
			end
		end
	end

endmodule

// ----- design/gpio_port_controller_change_events_top.sv -----
// Top level: GPIO port bank with pin-change event sequencer.
//
// Requests arrive on req (valid/ready): an action, a port letter, a bit index,
// a level and a pin byte. Results leave on rsp (valid/ready) from an output
// register; each request yields one result, except a sample that found
// changed pins, which yields one event per changed bit in ascending order,
// the final one flagged by last_result. Undefined actions yield no result.
// cfg_we/cfg_wdata set the flag that also write-protects pins H0 and H1.
// A request is taken in one cycle and evaluated in the next, so a single
// result is registered at the end of S_EXEC once rsp has room, and the next
// request is taken back in S_IDLE. A sample with changes then walks the
// changed-bit mask with one bit tester, one bit per cycle while rsp does
// not stall, up to its highest changed bit. req.ready is high only
// while the sequencer is idle; a new request is taken while a result still
// waits on rsp. When rsp stalls, the sequencer holds until the output
// register frees. Reset clears all latches, sampled pins and the flag.
`timescale 1ns / 1ps

`include "gpio_port_controller_change_events_top_assert.svh"

module gpio_port_controller_change_events_top #(
	parameter int NUM_PORTS = 11
) (
	input  logic              clk,
	input  logic              arst_n,
	gpce_req_if.sink          req,
	gpce_rsp_if.source        rsp,
	input  logic              cfg_we,
	input  logic              cfg_wdata
);

	gpce_pkg::seq_state_t state_q, state_d;

	logic [2:0] act_q;
	logic [7:0] letter_q;
	logic [7:0] bit_q;
	logic       level_q;
	logic [7:0] sample_q;
	logic       sec_uart_rsv_q;

	logic [7:0] diff_q, diff_d;
	logic [2:0] cnt_q, cnt_d;

	logic           rsp_valid_q;
	gpce_pkg::rsp_t rsp_q, rsp_d;
	logic           rsp_load;

	gpce_pkg::port_lookup_t lk;
	gpce_pkg::bank_wr_t     bank_wr;
	gpce_pkg::bank_rd_t     bank_rd;

	logic       port_known;
	logic       act_known;
	logic       bit_used;
	logic       bit_ok;
	logic       reserved;
	logic       slot_free;
	logic [7:0] diff_now;
	logic [7:0] cur_mask;
	logic       cur_bit;
	logic       last_evt;

	gpce_bank #(
		.NUM_PORTS(NUM_PORTS)
	) u_bank (
		.clk   (clk),
		.arst_n(arst_n),
		.idx   (lk.idx),
		.wr    (bank_wr),
		.rd    (bank_rd)
	);

	// decode of the held request and the bit tester
	always_comb begin
		lk         = gpce_pkg::port_lookup(letter_q);
		port_known = lk.hit && ({1'b0, lk.idx} < 5'(NUM_PORTS));
		act_known  = (act_q <= gpce_pkg::ACT_BASELINE);
		bit_used   = (act_q == gpce_pkg::ACT_WR_OUT) || (act_q == gpce_pkg::ACT_WR_DIR) ||
			(act_q == gpce_pkg::ACT_RD_PIN);
		bit_ok     = (bit_q[7:3] == 5'd0);
		reserved   = (bit_q[7:1] == 7'd0) && ((letter_q == gpce_pkg::LETTER_E) ||
			(sec_uart_rsv_q && (letter_q == gpce_pkg::LETTER_H)));
		slot_free  = !rsp_valid_q || rsp.ready;
		diff_now   = bank_rd.pins ^ sample_q;
		cur_mask   = 8'd1 << cnt_q;
		cur_bit    = diff_q[cnt_q];
		last_evt   = ((diff_q & ~cur_mask) == 8'd0);
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			gpce_pkg::S_IDLE: begin
				if (req.valid) begin
					state_d = gpce_pkg::S_EXEC;
				end
			end
			gpce_pkg::S_EXEC: begin
				if (!act_known) begin
					state_d = gpce_pkg::S_IDLE;
				end else if (slot_free) begin
					if (port_known && (act_q == gpce_pkg::ACT_SAMPLE) && (diff_now != 8'd0)) begin
						state_d = gpce_pkg::S_SCAN;
					end else begin
						state_d = gpce_pkg::S_IDLE;
					end
				end
			end
			gpce_pkg::S_SCAN: begin
				if (cur_bit && slot_free && last_evt) begin
					state_d = gpce_pkg::S_IDLE;
				end
			end
			default: state_d = gpce_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		req.ready       = (state_q == gpce_pkg::S_IDLE);
		bank_wr         = '0;
		bank_wr.bit_sel = bit_q[2:0];
		bank_wr.level   = level_q;
		bank_wr.pins    = sample_q;
		rsp_load        = 1'b0;
		rsp_d           = '0;
		diff_d          = diff_q;
		cnt_d           = cnt_q;
		unique case (state_q)
			gpce_pkg::S_IDLE: begin
				rsp_load = 1'b0;
			end
			gpce_pkg::S_EXEC: begin
				if (slot_free && act_known) begin
					rsp_d.last_result = 1'b1;
					if (!port_known) begin
						rsp_load     = 1'b1;
						rsp_d.status = gpce_pkg::ST_UNKNOWN_PORT;
					end else if (bit_used && !bit_ok) begin
						rsp_load        = 1'b1;
						rsp_d.status    = gpce_pkg::ST_BIT_RANGE;
						rsp_d.out_latch = bank_rd.out_nx;
						rsp_d.dir_latch = bank_rd.dir_nx;
					end else begin
						case (act_q) inside
							gpce_pkg::ACT_RD_PIN: begin
								rsp_load         = 1'b1;
								rsp_d.read_level = bank_rd.pins[bit_q[2:0]];
							end
							gpce_pkg::ACT_WR_OUT, gpce_pkg::ACT_WR_DIR: begin
								rsp_load = 1'b1;
								if (reserved) begin
									rsp_d.status = gpce_pkg::ST_RESERVED;
								end else begin
									bank_wr.out_we = (act_q == gpce_pkg::ACT_WR_OUT);
									bank_wr.dir_we = (act_q == gpce_pkg::ACT_WR_DIR);
								end
							end
							gpce_pkg::ACT_BASELINE: begin
								rsp_load       = 1'b1;
								bank_wr.pin_we = 1'b1;
							end
							gpce_pkg::ACT_SAMPLE: begin
								bank_wr.pin_we = 1'b1;
								if (diff_now == 8'd0) begin
									rsp_load = 1'b1;
								end else begin
									diff_d = diff_now;
									cnt_d  = 3'd0;
								end
							end
							default: rsp_load = 1'b0;
						endcase
						rsp_d.out_latch = bank_rd.out_nx;
						rsp_d.dir_latch = bank_rd.dir_nx;
					end
				end
			end
			gpce_pkg::S_SCAN: begin
				if (cur_bit) begin
					if (slot_free) begin
						rsp_load          = 1'b1;
						rsp_d.event_valid = 1'b1;
						rsp_d.event_port  = letter_q;
						rsp_d.event_bit   = cnt_q;
						rsp_d.event_level = sample_q[cnt_q];
						rsp_d.last_result = last_evt;
						rsp_d.out_latch   = bank_rd.out_nx;
						rsp_d.dir_latch   = bank_rd.dir_nx;
						diff_d            = diff_q & ~cur_mask;
						cnt_d             = cnt_q + 3'd1;
					end
				end else begin
					// skip unchanged pin
					cnt_d = cnt_q + 3'd1;
				end
			end
			default: rsp_load = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= gpce_pkg::S_IDLE;
			sec_uart_rsv_q <= 1'b0;
			rsp_valid_q    <= 1'b0;
			diff_q         <= 8'd0;
			cnt_q          <= 3'd0;
		end else begin
			state_q <= state_d;
			diff_q  <= diff_d;
			cnt_q   <= cnt_d;
			if (cfg_we) begin
				sec_uart_rsv_q <= cfg_wdata;
			end
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			act_q    <= req.action;
			letter_q <= req.port_letter;
			bit_q    <= req.bit_index;
			level_q  <= req.level;
			sample_q <= req.pin_sample;
		end
		if (rsp_load) begin
			rsp_q <= rsp_d;
		end
	end

	assign rsp.valid       = rsp_valid_q;
	assign rsp.status      = rsp_q.status;
	assign rsp.read_level  = rsp_q.read_level;
	assign rsp.event_valid = rsp_q.event_valid;
	assign rsp.event_port  = rsp_q.event_port;
	assign rsp.event_bit   = rsp_q.event_bit;
	assign rsp.event_level = rsp_q.event_level;
	assign rsp.last_result = rsp_q.last_result;
	assign rsp.out_latch   = rsp_q.out_latch;
	assign rsp.dir_latch   = rsp_q.dir_latch;

	`GPCE_ASSERT_NEXT(a_accept_to_exec, clk, arst_n, req.valid && req.ready,
		state_q == gpce_pkg::S_EXEC)
	`GPCE_ASSERT_IMPL(a_scan_has_changes, clk, arst_n, state_q == gpce_pkg::S_SCAN,
		diff_q != 8'd0)
	`GPCE_ASSERT_IMPL(a_scan_no_write, clk, arst_n, state_q == gpce_pkg::S_SCAN,
		!(bank_wr.out_we || bank_wr.dir_we || bank_wr.pin_we))
	`GPCE_ASSERT_IMPL(a_only_events_continue, clk, arst_n, rsp_valid_q && !rsp_q.last_result,
		rsp_q.event_valid && (rsp_q.status == gpce_pkg::ST_OK))

endmodule
